// File: rtl/core/lstm_pkg.sv
// Shared types, codes and constants of the sharpening tone map block.
`timescale 1ns / 1ps

package lstm_pkg;

	// Configuration register indexes
	localparam logic REG_BETA_GAIN   = 1'b0;
	localparam logic REG_LINE_LENGTH = 1'b1;

	// Result jobs of one pixel, in emission order
	localparam logic [1:0] JOB_PREV      = 2'd0; // previous row, this column
	localparam logic [1:0] JOB_FIN_LEFT  = 2'd1; // final row, column to the left
	localparam logic [1:0] JOB_FIN_LAST  = 2'd2; // final row, last column
	localparam logic [1:0] JOB_PLAIN     = 2'd3; // plain tone map, no sharpening
	localparam int         NUM_JOBS      = 4;

	// Divisor 256*255*n for n neighbours; n of zero uses the n = 1 value
	localparam logic [17:0] DEN_1 = 18'd65280;
	localparam logic [17:0] DEN_2 = 18'd130560;
	localparam logic [17:0] DEN_3 = 18'd195840;
	localparam logic [17:0] DEN_4 = 18'd261120;

	// Reciprocals of 255*n scaled by 2^32, rounded up; exact for dividends below 2^22
	localparam int          RCP_SHIFT = 32;
	localparam logic [24:0] RCP_1     = 25'd16843010;
	localparam logic [24:0] RCP_2     = 25'd8421505;
	localparam logic [24:0] RCP_3     = 25'd5614337;
	localparam logic [24:0] RCP_4     = 25'd4210753;

	// Quotient bits
	localparam int QW = 12;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       accept;
		logic       lat1;
		logic       lat2;
		logic       lat3;
		logic       commit;
		logic       mul1;
		logic       mul2;
		logic       prep;
		logic       div_step;
		logic       emit;
		logic [1:0] job;
	} lstm_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic                is_map;
		logic [NUM_JOBS-1:0] job_valid;
		logic                out_free;
	} lstm_stat_t;

	function automatic logic [17:0] den_of(input logic [2:0] n);
		logic [17:0] d;
		unique case (n)
			3'd2:    d = DEN_2;
			3'd3:    d = DEN_3;
			3'd4:    d = DEN_4;
			default: d = DEN_1;
		endcase
		return d;
	endfunction

	function automatic logic [24:0] rcp_of(input logic [2:0] n);
		logic [24:0] r;
		unique case (n)
			3'd2:    r = RCP_2;
			3'd3:    r = RCP_3;
			3'd4:    r = RCP_4;
			default: r = RCP_1;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/lstm_dp.sv
// Datapath: tone table, line stores, counters, multipliers, reciprocal divide, output register.
`timescale 1ns / 1ps

module lstm_dp #(
	parameter int MAX_LINE = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lstm_pkg::lstm_cmd_t cmd,
	output lstm_pkg::lstm_stat_t stat,
	input  logic                in_command,
	input  logic [7:0]          in_pixel,
	input  logic                in_final,
	input  logic [7:0]          in_map_index,
	input  logic [7:0]          in_map_value,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [11:0]         cfg_wdata,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [7:0]          out_pixel,
	output logic                out_row_end,
	output logic                out_image_end,
	output logic                out_run_last
);

	localparam int AW   = $clog2(MAX_LINE);
	localparam int CW   = (AW + 1 > 12) ? AW + 1 : 12;
	localparam int QW_L = lstm_pkg::QW;

	// Stores
	logic [7:0] tone_mem [256];
	logic [7:0] cen_mem  [MAX_LINE];
	logic [7:0] up_mem   [MAX_LINE];

	logic [7:0] tone_rd_q, cen_rd_q, up_rd_q;

	// Configuration and position state
	logic [11:0]   beta_q, line_q;
	logic [AW-1:0] col_q;
	logic [1:0]    rows_seen_q;

	// Per-pixel latches
	logic [AW-1:0] c_q;
	logic          last_q, fin_q;
	logic [1:0]    rows_q;
	logic [7:0]    m_q, cen_c_q, up_c_q, cen_r_q, up_l_q, cen_l_q, cen_ll_q;

	// Arithmetic registers
	logic [7:0]         p_q;
	logic [19:0]        prod_q;
	logic signed [11:0] lap_q;
	logic [2:0]         n_q;
	logic signed [32:0] num_q;
	logic               neg_q;
	logic [21:0]        y_q;
	logic [24:0]        rcp_q;
	logic [QW_L-1:0]    quo_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_px_q;
	logic       out_re_q, out_ie_q, out_rl_q;

	// Effective row length and current column
	logic [CW-1:0] len_w, lenm1_w;
	logic [AW-1:0] lenm1, c_now;

	always_comb begin
		if (line_q == 12'd0) begin
			len_w = CW'(1);
		end else if (CW'(line_q) > CW'(MAX_LINE)) begin
			len_w = CW'(MAX_LINE);
		end else begin
			len_w = CW'(line_q);
		end
		lenm1_w = len_w - CW'(1);
		lenm1   = lenm1_w[AW-1:0];
		c_now   = (col_q > lenm1) ? lenm1 : col_q;
	end

	// Store read addresses
	logic [AW-1:0] cen_ra, up_ra;

	always_comb begin
		cen_ra = c_now;
		up_ra  = c_now;
		if (cmd.lat1) begin
			cen_ra = c_q + AW'(1);
			up_ra  = c_q - AW'(1);
		end else if (cmd.lat2) begin
			cen_ra = c_q - AW'(1);
		end else if (cmd.lat3) begin
			cen_ra = c_q - AW'(2);
		end
	end

	// Tone table
	always_ff @(posedge clk) begin
		if (cmd.accept && in_command) begin
			tone_mem[in_map_index] <= in_map_value;
		end
		tone_rd_q <= tone_mem[in_pixel];
	end

	// Centre row store
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			cen_mem[c_q] <= m_q;
		end
		cen_rd_q <= cen_mem[cen_ra];
	end

	// Upper row store
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			up_mem[c_q] <= cen_c_q;
		end
		up_rd_q <= up_mem[up_ra];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= 12'd0;
			line_q <= 12'd512;
		end else if (cfg_we) begin
			if (cfg_idx == lstm_pkg::REG_BETA_GAIN) begin
				beta_q <= cfg_wdata;
			end else begin
				line_q <= cfg_wdata;
			end
		end
	end

	// Column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			rows_seen_q <= 2'd0;
		end else if (cmd.commit) begin
			if (last_q) begin
				col_q <= '0;
				if (fin_q) begin
					rows_seen_q <= 2'd0;
				end else if (rows_q < 2'd2) begin
					rows_seen_q <= rows_q + 2'd1;
				end
			end else begin
				col_q <= c_q + AW'(1);
			end
		end
	end

	// Pixel latches and neighbour capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			c_q    <= c_now;
			last_q <= (c_now == lenm1);
			fin_q  <= in_final;
			rows_q <= rows_seen_q;
		end
		if (cmd.lat1) begin
			m_q     <= tone_rd_q;
			cen_c_q <= cen_rd_q;
			up_c_q  <= up_rd_q;
		end
		if (cmd.lat2) begin
			cen_r_q <= cen_rd_q;
			up_l_q  <= up_rd_q;
		end
		if (cmd.lat3) begin
			cen_l_q <= cen_rd_q;
		end
		if (cmd.commit) begin
			cen_ll_q <= cen_rd_q;
		end
	end

	// Jobs that this pixel produces
	logic                          bz;
	logic [lstm_pkg::NUM_JOBS-1:0] jv;

	always_comb begin
		bz                           = (beta_q == 12'd0);
		jv[lstm_pkg::JOB_PREV]       = !bz && (rows_q != 2'd0);
		jv[lstm_pkg::JOB_FIN_LEFT]   = !bz && fin_q && (c_q != '0);
		jv[lstm_pkg::JOB_FIN_LAST]   = !bz && fin_q && last_q;
		jv[lstm_pkg::JOB_PLAIN]      = bz;
	end

	// Operand selection for the current job
	logic [7:0] sel_p;
	logic [9:0] sel_sum;
	logic [2:0] sel_n;
	logic       sel_re, sel_ie, sel_rl;

	always_comb begin
		sel_p   = m_q;
		sel_sum = 10'd0;
		sel_n   = 3'd0;
		sel_re  = 1'b0;
		sel_ie  = 1'b0;
		sel_rl  = 1'b1;
		case (cmd.job)
			lstm_pkg::JOB_PREV: begin
				sel_p   = cen_c_q;
				sel_sum = 10'(m_q);
				sel_n   = 3'd1;
				if (rows_q >= 2'd2) begin
					sel_sum = sel_sum + 10'(up_c_q);
					sel_n   = sel_n + 3'd1;
				end
				if (c_q != '0) begin
					sel_sum = sel_sum + 10'(up_l_q);
					sel_n   = sel_n + 3'd1;
				end
				if (!last_q) begin
					sel_sum = sel_sum + 10'(cen_r_q);
					sel_n   = sel_n + 3'd1;
				end
				sel_re = last_q;
				sel_rl = !(jv[lstm_pkg::JOB_FIN_LEFT] || jv[lstm_pkg::JOB_FIN_LAST]);
			end
			lstm_pkg::JOB_FIN_LEFT: begin
				sel_p   = cen_l_q;
				sel_sum = 10'(m_q);
				sel_n   = 3'd1;
				if (rows_q != 2'd0) begin
					sel_sum = sel_sum + 10'(up_l_q);
					sel_n   = sel_n + 3'd1;
				end
				if (c_q > AW'(1)) begin
					sel_sum = sel_sum + 10'(cen_ll_q);
					sel_n   = sel_n + 3'd1;
				end
				sel_rl = !jv[lstm_pkg::JOB_FIN_LAST];
			end
			lstm_pkg::JOB_FIN_LAST: begin
				sel_p = m_q;
				if (rows_q != 2'd0) begin
					sel_sum = sel_sum + 10'(cen_c_q);
					sel_n   = sel_n + 3'd1;
				end
				if (c_q != '0) begin
					sel_sum = sel_sum + 10'(cen_l_q);
					sel_n   = sel_n + 3'd1;
				end
				sel_re = 1'b1;
				sel_ie = 1'b1;
			end
			default: begin
				// plain map: no neighbours, result is the mapped pixel
				sel_re = last_q;
				sel_ie = last_q && fin_q;
			end
		endcase
	end

	// Laplacian and first product
	logic [10:0] np;
	assign np = 11'(sel_n) * 11'(sel_p);

	// Rounded magnitude; dividing by 256 first leaves a divide by 255*n
	logic [32:0] mag;
	logic [32:0] rnd;
	logic [17:0] den;
	assign den = lstm_pkg::den_of(n_q);
	assign mag = num_q[32] ? 33'(-num_q) : 33'(num_q);
	assign rnd = mag + (num_q[32] ? 33'd0 : 33'(den - 18'd1));

	// Quotient by reciprocal multiply
	logic [46:0] qprod;
	assign qprod = {25'd0, y_q} * {22'd0, rcp_q};

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			p_q    <= sel_p;
			n_q    <= sel_n;
			prod_q <= 20'(beta_q) * 20'(sel_p);
			lap_q  <= $signed(12'(sel_sum)) - $signed(12'(np));
		end
		if (cmd.mul2) begin
			num_q <= $signed({13'd0, prod_q}) * 33'(lap_q);
		end
		if (cmd.prep) begin
			neg_q <= num_q[32];
			y_q   <= rnd[29:8];
			rcp_q <= lstm_pkg::rcp_of(n_q);
		end
		if (cmd.div_step) begin
			quo_q <= qprod[lstm_pkg::RCP_SHIFT +: QW_L];
		end
	end

	// Final value with clamp
	logic signed [13:0] v;
	logic [7:0]         v_clamp;

	always_comb begin
		if (neg_q) begin
			v = $signed(14'(p_q)) + $signed(14'(quo_q));
		end else begin
			v = $signed(14'(p_q)) - $signed(14'(quo_q));
		end
		if (v < 0) begin
			v_clamp = 8'd0;
		end else if (v > 14'sd255) begin
			v_clamp = 8'd255;
		end else begin
			v_clamp = v[7:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_px_q <= v_clamp;
			out_re_q <= sel_re;
			out_ie_q <= sel_ie;
			out_rl_q <= sel_rl;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pixel     = out_px_q;
	assign out_row_end   = out_re_q;
	assign out_image_end = out_ie_q;
	assign out_run_last  = out_rl_q;

	// Status
	assign stat.is_map    = in_command;
	assign stat.job_valid = jv;
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

// File: rtl/core/lstm_ctrl.sv
// Controller: sequences store reads, the write back and the result jobs of each pixel.
`timescale 1ns / 1ps

module lstm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lstm_pkg::lstm_stat_t stat,
	output lstm_pkg::lstm_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_RD3,
		S_WR,
		S_JSEL,
		S_MUL1,
		S_MUL2,
		S_PREP,
		S_DIV,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] job_q;

	// State and job counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= 2'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					job_q <= 2'd0;
					if (in_valid && !stat.is_map) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_WR;
				S_WR:  state_q <= S_JSEL;
				S_JSEL: begin
					if (stat.job_valid[job_q]) begin
						state_q <= S_MUL1;
					end else if (job_q == lstm_pkg::JOB_PLAIN) begin
						state_q <= S_IDLE;
					end else begin
						job_q <= job_q + 2'd1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_PREP;
				S_PREP: state_q <= S_DIV;
				S_DIV:  state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free) begin
						if (job_q == lstm_pkg::JOB_PLAIN) begin
							state_q <= S_IDLE;
						end else begin
							job_q   <= job_q + 2'd1;
							state_q <= S_JSEL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode
	assign in_ready     = (state_q == S_IDLE);
	assign cmd.accept   = (state_q == S_IDLE) && in_valid;
	assign cmd.lat1     = (state_q == S_RD1);
	assign cmd.lat2     = (state_q == S_RD2);
	assign cmd.lat3     = (state_q == S_RD3);
	assign cmd.commit   = (state_q == S_WR);
	assign cmd.mul1     = (state_q == S_MUL1);
	assign cmd.mul2     = (state_q == S_MUL2);
	assign cmd.prep     = (state_q == S_PREP);
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.emit     = (state_q == S_EMIT) && stat.out_free;
	assign cmd.job      = job_q;

endmodule

// File: rtl/core/laplacian_sharpen_tone_map_top.sv
// Top level of the Laplacian sharpening tone map block.
`timescale 1ns / 1ps

// Grey pixels enter in raster order with tuser low; a word with tuser high writes one
// tone map entry. Each pixel is mapped, then, with a nonzero beta gain, the previous
// row is sharpened with a 3x3 cross Laplacian as the next row arrives; a row with
// tlast set is the final one and is emitted alongside. One pixel is worked on at a
// time: line store access and write back, a job scan, and for each result two
// multiply stages, rounding setup, a reciprocal multiply for the divide by 65280*n
// and an output load that waits while the output register is full; a pixel gives up
// to three results. Results wait in an output register, so a new word is taken while
// the last result is still pending.

module laplacian_sharpen_tone_map_top #(
	parameter int MAX_LINE = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pixel_in, map_index, map_value
	input  logic        s_axis_tlast,  // final_row
	input  logic        s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // pixel_out
	output logic        m_axis_tlast,  // row_end
	output logic [1:0]  m_axis_tuser,  // image_end, run_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	lstm_pkg::lstm_cmd_t  cmd;
	lstm_pkg::lstm_stat_t stat;

	assign cfg_ready = 1'b1;

	lstm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lstm_dp #(
		.MAX_LINE (MAX_LINE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_command    (s_axis_tuser),
		.in_pixel      (s_axis_tdata[7:0]),
		.in_final      (s_axis_tlast),
		.in_map_index  (s_axis_tdata[15:8]),
		.in_map_value  (s_axis_tdata[23:16]),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_idx       (cfg_index),
		.cfg_wdata     (cfg_data),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_pixel     (m_axis_tdata),
		.out_row_end   (m_axis_tlast),
		.out_image_end (m_axis_tuser[0]),
		.out_run_last  (m_axis_tuser[1])
	);

endmodule
